>>> design/owm_pkg.sv
// Package for the 1-Wire byte master: command codes, register indexes,
// register reset values, phase codes and default parameters.
// No dependencies.
package owm_pkg;

  localparam int unsigned TickBitsDef = 10;
  localparam int unsigned CfgW        = 10;
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned NumCfg      = 8;
  localparam int unsigned PhaseW      = 4;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CmdTick  = 2'd0;
  localparam cmd_t CmdReset = 2'd1;
  localparam cmd_t CmdWrite = 2'd2;
  localparam cmd_t CmdRead  = 2'd3;

  localparam logic [CfgIdxW-1:0] RegResetLow   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegReadLow    = 8'd1;
  localparam logic [CfgIdxW-1:0] RegReadSample = 8'd2;
  localparam logic [CfgIdxW-1:0] RegReadRecov  = 8'd3;
  localparam logic [CfgIdxW-1:0] RegOneLow     = 8'd4;
  localparam logic [CfgIdxW-1:0] RegOneHigh    = 8'd5;
  localparam logic [CfgIdxW-1:0] RegZeroLow    = 8'd6;
  localparam logic [CfgIdxW-1:0] RegZeroHigh   = 8'd7;

  localparam logic [CfgW-1:0] RstResetLow   = 10'd750;
  localparam logic [CfgW-1:0] RstReadLow    = 10'd5;
  localparam logic [CfgW-1:0] RstReadSample = 10'd15;
  localparam logic [CfgW-1:0] RstReadRecov  = 10'd60;
  localparam logic [CfgW-1:0] RstOneLow     = 10'd5;
  localparam logic [CfgW-1:0] RstOneHigh    = 10'd85;
  localparam logic [CfgW-1:0] RstZeroLow    = 10'd90;
  localparam logic [CfgW-1:0] RstZeroHigh   = 10'd5;

  localparam logic [PhaseW-1:0] PhIdle       = 4'd0;
  localparam logic [PhaseW-1:0] PhRstLow     = 4'd1;
  localparam logic [PhaseW-1:0] PhRstWaitLo  = 4'd2;
  localparam logic [PhaseW-1:0] PhRstWaitHi  = 4'd3;
  localparam logic [PhaseW-1:0] PhWrLow      = 4'd4;
  localparam logic [PhaseW-1:0] PhWrHigh     = 4'd5;
  localparam logic [PhaseW-1:0] PhRdLow      = 4'd6;
  localparam logic [PhaseW-1:0] PhRdWait     = 4'd7;
  localparam logic [PhaseW-1:0] PhRdWaitHi   = 4'd8;
  localparam logic [PhaseW-1:0] PhRdRecover  = 4'd9;

endpackage

>>> design/onewire_bus_master_unit.sv
// Top level of the 1-Wire byte master: command/tick stream in, bus status out.
// Depends on owm_pkg.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: write_byte, line_level; tuser: cmd
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: drive_low, busy, done, read_byte, rejected
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item per clock while the output is not back-pressured: the phase machine and the
// result register update on the cycle an item is taken, and the result shows in the cycle after.
// The input is taken whenever the result register is empty or being drained.
// Reset returns the config registers to their defaults and the machine to idle.
// Config writes are always accepted.
module onewire_bus_master_unit #(
  parameter int unsigned TICK_BITS = owm_pkg::TickBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [7:0] write_byte, [8] line_level
  input  logic [1:0]                    s_axis_tuser,  // [1:0] cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_byte, [11] rejected
  output logic [15:0]                   m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [owm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [owm_pkg::CfgW-1:0]      cfg_data_i
);
  import owm_pkg::*;

  localparam int unsigned CmpW = (TICK_BITS > CfgW) ? TICK_BITS : CfgW;
  localparam logic [TICK_BITS-1:0] TickMax = {TICK_BITS{1'b1}};

  logic [CfgW-1:0] cfg_q [NumCfg];

  logic [PhaseW-1:0]    phase_q, phase_d;
  logic [TICK_BITS-1:0] cnt_q, cnt_d;
  logic [2:0]           bit_q, bit_d;
  logic [7:0]           shift_q, shift_d;
  logic [7:0]           rbyte_q, rbyte_d;

  logic        out_vld_q;
  logic [15:0] out_data_q, out_data_d;

  logic        accept;
  cmd_t        cmd;
  logic [7:0]  wbyte;
  logic        level;
  logic        one;
  logic        done, rej;

  logic [CfgW-1:0]      dur;
  logic [CmpW-1:0]      dur_ext, lim_ext;
  logic [TICK_BITS-1:0] lim, cnt_inc, cnt_el;
  logic                 hit;
  logic [CfgW-1:0]      high_dur;
  logic [7:0]           shift_smp;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  assign cmd   = s_axis_tuser;
  assign wbyte = s_axis_tdata[7:0];
  assign level = s_axis_tdata[8];
  assign one   = shift_q[0];

  assign high_dur  = one ? cfg_q[RegOneHigh[2:0]] : cfg_q[RegZeroHigh[2:0]];
  assign shift_smp = {level, shift_q[7:1]};

  // duration of the current timed phase
  always_comb begin
    case (phase_q)
      PhRstLow:    dur = cfg_q[RegResetLow[2:0]];
      PhWrLow:     dur = one ? cfg_q[RegOneLow[2:0]] : cfg_q[RegZeroLow[2:0]];
      PhWrHigh:    dur = high_dur;
      PhRdLow:     dur = cfg_q[RegReadLow[2:0]];
      PhRdWait:    dur = cfg_q[RegReadSample[2:0]];
      PhRdRecover: dur = cfg_q[RegReadRecov[2:0]];
      default:     dur = '0;
    endcase
  end

  // saturating tick counter against the clamped duration
  assign dur_ext = CmpW'(dur);
  assign lim_ext = (dur_ext > CmpW'(TickMax)) ? CmpW'(TickMax) : dur_ext;
  assign lim     = lim_ext[TICK_BITS-1:0];
  assign cnt_inc = (cnt_q == TickMax) ? cnt_q : cnt_q + 1'b1;
  assign hit     = cnt_inc >= lim;
  assign cnt_el  = hit ? '0 : cnt_inc;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    rbyte_d = rbyte_q;
    done    = 1'b0;
    rej     = 1'b0;

    if (cmd == CmdTick) begin
      case (phase_q)
        PhIdle: begin
        end
        PhRstLow: begin
          cnt_d = cnt_el;
          if (hit) phase_d = PhRstWaitLo;
        end
        PhRstWaitLo: begin
          if (!level) phase_d = PhRstWaitHi;
        end
        PhRstWaitHi: begin
          if (level) begin
            phase_d = PhIdle;
            done    = 1'b1;
          end
        end
        PhWrLow, PhWrHigh: begin
          cnt_d = cnt_el;
          if (hit) begin
            if (phase_q == PhWrLow && high_dur != '0) begin
              phase_d = PhWrHigh;
            end else if (bit_q == 3'd7) begin
              phase_d = PhIdle;
              bit_d   = '0;
              done    = 1'b1;
            end else begin
              phase_d = PhWrLow;
              bit_d   = bit_q + 3'd1;
              shift_d = {1'b0, shift_q[7:1]};
            end
          end
        end
        PhRdLow: begin
          cnt_d = cnt_el;
          if (hit) phase_d = PhRdWait;
        end
        PhRdWait, PhRdWaitHi, PhRdRecover: begin
          logic slot_end;
          logic [7:0] sh;
          slot_end = 1'b0;
          sh       = shift_q;
          if (phase_q == PhRdWait) begin
            cnt_d = cnt_el;
            if (hit) begin
              sh      = shift_smp;
              shift_d = shift_smp;
              if (!level) phase_d = PhRdWaitHi;
              else if (cfg_q[RegReadRecov[2:0]] == '0) slot_end = 1'b1;
              else phase_d = PhRdRecover;
            end
          end else if (phase_q == PhRdWaitHi) begin
            if (level) begin
              if (cfg_q[RegReadRecov[2:0]] == '0) slot_end = 1'b1;
              else phase_d = PhRdRecover;
            end
          end else begin
            cnt_d = cnt_el;
            if (hit) slot_end = 1'b1;
          end
          if (slot_end) begin
            if (bit_q == 3'd7) begin
              rbyte_d = sh;
              phase_d = PhIdle;
              bit_d   = '0;
              done    = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = PhRdLow;
            end
          end
        end
        default: phase_d = PhIdle;
      endcase
    end else if (phase_q != PhIdle) begin
      rej = 1'b1;
    end else begin
      cnt_d = '0;
      bit_d = '0;
      case (cmd)
        CmdReset: phase_d = PhRstLow;
        CmdWrite: begin
          shift_d = wbyte;
          phase_d = PhWrLow;
        end
        default: begin
          shift_d = '0;
          phase_d = PhRdLow;
        end
      endcase
    end

    out_data_d        = '0;
    out_data_d[0]     = (phase_d == PhRstLow) || (phase_d == PhWrLow) || (phase_d == PhRdLow);
    out_data_d[1]     = phase_d != PhIdle;
    out_data_d[2]     = done;
    out_data_d[10:3]  = rbyte_d;
    out_data_d[11]    = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[RegResetLow[2:0]]   <= RstResetLow;
      cfg_q[RegReadLow[2:0]]    <= RstReadLow;
      cfg_q[RegReadSample[2:0]] <= RstReadSample;
      cfg_q[RegReadRecov[2:0]]  <= RstReadRecov;
      cfg_q[RegOneLow[2:0]]     <= RstOneLow;
      cfg_q[RegOneHigh[2:0]]    <= RstOneHigh;
      cfg_q[RegZeroLow[2:0]]    <= RstZeroLow;
      cfg_q[RegZeroHigh[2:0]]   <= RstZeroHigh;
    end else if (cfg_valid_i && cfg_index_i < CfgIdxW'(NumCfg)) begin
      cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      cnt_q     <= '0;
      bit_q     <= '0;
      shift_q   <= '0;
      rbyte_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        rbyte_q <= rbyte_d;
      end
      if (accept) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_data_q <= out_data_d;
  end

endmodule
